/* rtl/rph_pkg.sv */
// Shared types, constants and MD5 tables for the RADIUS password hiding block.
// No dependencies; every other file of the block but rph_ifs and rph_ram uses it by scoped names.
`default_nettype none
package rph_pkg;

   localparam int MAX_SECRET_BYTES   = 64;
   localparam int MAX_PASSWORD_BYTES = 128;
   localparam int AUTH_BYTES         = 16;
   localparam int SL_W               = 7;
   localparam int SADDR_W            = $clog2(MAX_SECRET_BYTES);
   localparam int POS_W              = 8;
   localparam int QUEUE_DEPTH        = 4;
   localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W             = QPTR_W + 1;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [SL_W-1:0] SECRET_LENGTH_RESET = 7'd1;
   localparam logic            REG_SECRET_LENGTH   = 1'b0;

   typedef enum logic [1:0] {
      KIND_SECRET = 2'd0,
      KIND_AUTH   = 2'd1,
      KIND_BYTE   = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   op;
      logic [5:0] index;
      logic [7:0] value;
   } item_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md5_status_type;

   typedef enum logic [2:0] {
      MD_IDLE,
      MD_FILL,
      MD_RND_A,
      MD_RND_B,
      MD_ADD
   } md5_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_START,
      BK_HASH,
      BK_EMIT
   } back_state_type;

   localparam logic [31:0] MD5_IV [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] MD5_ROT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word index for round i
   function automatic logic [3:0] md5_g(input logic [5:0] i);
      logic [3:0] t;
      logic [3:0] g;
      t = i[3:0];
      case (i[5:4])
         2'd0:    g = t;
         2'd1:    g = t * 4'd5 + 4'd1;
         2'd2:    g = t * 4'd3 + 4'd5;
         default: g = t * 4'd7;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

/* rtl/rph_ifs.sv */
// Request and response channel interfaces of the password hiding block.
// No dependencies; the fields are plain logic vectors.
`default_nettype none
interface rph_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [5:0] index;
   logic [7:0] value;
   modport source (output valid, kind, index, value, input ready);
   modport sink   (input valid, kind, index, value, output ready);
endinterface

interface rph_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] encoded_byte;
   logic       last;
   modport source (output valid, encoded_byte, last, input ready);
   modport sink   (input valid, encoded_byte, last, output ready);
endinterface
`default_nettype wire

/* rtl/rph_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

/* rtl/rph_front.sv */
// Front end: accepts requests, drops out-of-range loads, queues the rest.
// Depends on rph_pkg and rph_ifs.
`default_nettype none
module rph_front (
   input  wire logic               clock,
   input  wire logic               reset,
   rph_req_if.sink                 req_ch,
   output rph_pkg::item_type       q_item,
   output logic                    q_valid,
   input  wire logic               q_ready
);
   rph_pkg::item_type              q_ff [rph_pkg::QUEUE_DEPTH];
   rph_pkg::item_type              q_in [rph_pkg::QUEUE_DEPTH];
   logic [rph_pkg::QPTR_W-1:0]     wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [rph_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                           push, pop, keep;
   rph_pkg::item_type              cls;

   always_comb begin
      cls.op    = rph_pkg::kind_type'(req_ch.kind);
      cls.index = req_ch.index;
      cls.value = req_ch.value;
      case (cls.op)
         rph_pkg::KIND_SECRET:
            keep = {1'b0, req_ch.index} < rph_pkg::SL_W'(rph_pkg::MAX_SECRET_BYTES);
         rph_pkg::KIND_AUTH:
            keep = {1'b0, req_ch.index} < rph_pkg::SL_W'(rph_pkg::AUTH_BYTES);
         default:
            keep = 1'b1;
      endcase
   end

   assign req_ch.ready = cnt_ff < rph_pkg::QCNT_W'(rph_pkg::QUEUE_DEPTH);
   assign push         = req_ch.valid && req_ch.ready && keep;
   assign q_valid      = cnt_ff != '0;
   assign pop          = q_valid && q_ready;
   assign q_item       = q_ff[rptr_ff];

   always_comb begin
      q_in    = q_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (push) begin
         q_in[wptr_ff] = cls;
         wptr_in       = wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = rptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + rph_pkg::QCNT_W'(push) - rph_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/rph_md5.sv */
// Iterative MD5 over secret || chain block: byte fill, then each round in MD_RND_A and MD_RND_B.
// Depends on rph_pkg; reads the secret through a registered-read RAM port.
`default_nettype none
module rph_md5 (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rph_pkg::SL_W-1:0]   sl,
   input  wire logic [127:0]               chain,
   input  wire logic [7:0]                 ram_rdata,
   output logic [rph_pkg::SADDR_W-1:0]     ram_raddr,
   output rph_pkg::md5_status_type         status,
   output logic [127:0]                    digest
);
   rph_pkg::md5_state_type state_ff, state_in;
   logic [31:0] m_ff [16];
   logic [31:0] m_in [16];
   logic [31:0] h_ff [4];
   logic [31:0] h_in [4];
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, t_ff, t_in;
   logic [5:0]  i_ff, i_in;
   logic [6:0]  j_ff, j_in;
   logic        blk_ff, blk_in, two_ff, two_in, done_ff, done_in;
   logic        wr_valid_ff, wr_valid_in, wr_sec_ff, wr_sec_in;
   logic [5:0]  wr_pos_ff, wr_pos_in;
   logic [7:0]  wr_byte_ff, wr_byte_in;
   logic [6:0]  gj, len, lo_idx, cidx;
   logic [9:0]  bits;
   logic        src_sec;
   logic [7:0]  src_byte, wbyte;
   logic [31:0] f, sum_a, sum_b, sum_c, sum_d;
   logic [63:0] dbl;

   function automatic logic [4:0] MD5_ROT_SEL(input logic [5:0] i);
      return rph_pkg::MD5_ROT[{i[5:4], i[1:0]}];
   endfunction

   // message byte source for the global byte index being issued
   always_comb begin
      gj     = {blk_ff, j_ff[5:0]};
      len    = sl + 7'd16;
      bits   = {len, 3'b000};
      lo_idx = two_ff ? 7'd120 : 7'd56;
      cidx   = gj - sl;
      src_sec  = 1'b0;
      src_byte = 8'h00;
      if (gj < sl) begin
         src_sec = 1'b1;
      end else if (gj < len) begin
         src_byte = chain[{cidx[3:0], 3'b000} +: 8];
      end else if (gj == len) begin
         src_byte = 8'h80;
      end else if (gj == lo_idx) begin
         src_byte = bits[7:0];
      end else if (gj == lo_idx + 7'd1) begin
         src_byte = {6'b000000, bits[9:8]};
      end
   end

   always_comb begin
      case (i_ff[5:4])
         2'd0:    f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2:    f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      dbl   = {t_ff, t_ff} << MD5_ROT_SEL(i_ff);
      sum_a = h_ff[0] + a_ff;
      sum_b = h_ff[1] + b_ff;
      sum_c = h_ff[2] + c_ff;
      sum_d = h_ff[3] + d_ff;
      wbyte = wr_sec_ff ? ram_rdata : wr_byte_ff;
   end

   // next state
   always_comb begin
      case (state_ff)
         rph_pkg::MD_IDLE:  state_in = start ? rph_pkg::MD_FILL : rph_pkg::MD_IDLE;
         rph_pkg::MD_FILL:  state_in = j_ff[6] ? rph_pkg::MD_RND_A : rph_pkg::MD_FILL;
         rph_pkg::MD_RND_A: state_in = rph_pkg::MD_RND_B;
         rph_pkg::MD_RND_B: state_in = (i_ff == 6'd63) ? rph_pkg::MD_ADD : rph_pkg::MD_RND_A;
         rph_pkg::MD_ADD:   state_in = (two_ff && !blk_ff) ? rph_pkg::MD_FILL
                                                           : rph_pkg::MD_IDLE;
         default:           state_in = rph_pkg::MD_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      status.busy = state_ff != rph_pkg::MD_IDLE;
      status.done = done_ff;
      ram_raddr   = gj[5:0];
      digest      = {h_ff[3], h_ff[2], h_ff[1], h_ff[0]};
   end

   // datapath
   always_comb begin
      m_in = m_ff;  h_in = h_ff;
      a_in = a_ff;  b_in = b_ff;  c_in = c_ff;  d_in = d_ff;  t_in = t_ff;
      i_in = i_ff;  j_in = j_ff;  blk_in = blk_ff;  two_in = two_ff;
      done_in     = 1'b0;
      wr_valid_in = 1'b0;
      wr_pos_in   = wr_pos_ff;
      wr_sec_in   = wr_sec_ff;
      wr_byte_in  = wr_byte_ff;
      if (wr_valid_ff) begin
         m_in[wr_pos_ff[5:2]][{wr_pos_ff[1:0], 3'b000} +: 8] = wbyte;
      end
      case (state_ff)
         rph_pkg::MD_IDLE: begin
            if (start) begin
               h_in   = rph_pkg::MD5_IV;
               a_in   = rph_pkg::MD5_IV[0];
               b_in   = rph_pkg::MD5_IV[1];
               c_in   = rph_pkg::MD5_IV[2];
               d_in   = rph_pkg::MD5_IV[3];
               blk_in = 1'b0;
               j_in   = '0;
               two_in = len >= 7'd56;
            end
         end
         rph_pkg::MD_FILL: begin
            i_in = '0;
            if (!j_ff[6]) begin
               wr_valid_in = 1'b1;
               wr_pos_in   = j_ff[5:0];
               wr_sec_in   = src_sec;
               wr_byte_in  = src_byte;
               j_in        = j_ff + 7'd1;
            end
         end
         rph_pkg::MD_RND_A: begin
            t_in = f + a_ff + rph_pkg::MD5_K[i_ff] + m_ff[rph_pkg::md5_g(i_ff)];
         end
         rph_pkg::MD_RND_B: begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = b_ff + dbl[63:32];
            i_in = i_ff + 6'd1;
         end
         rph_pkg::MD_ADD: begin
            h_in[0] = sum_a;  h_in[1] = sum_b;  h_in[2] = sum_c;  h_in[3] = sum_d;
            a_in = sum_a;  b_in = sum_b;  c_in = sum_c;  d_in = sum_d;
            blk_in  = 1'b1;
            j_in    = '0;
            done_in = !(two_ff && !blk_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;  h_ff <= h_in;
      a_ff <= a_in;  b_ff <= b_in;  c_ff <= c_in;  d_ff <= d_in;  t_ff <= t_in;
      i_ff <= i_in;  j_ff <= j_in;  blk_ff <= blk_in;  two_ff <= two_in;
      wr_pos_ff  <= wr_pos_in;
      wr_sec_ff  <= wr_sec_in;
      wr_byte_ff <= wr_byte_in;
      if (reset) begin
         state_ff    <= rph_pkg::MD_IDLE;
         done_ff     <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         done_ff     <= done_in;
         wr_valid_ff <= wr_valid_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/rph_back.sv */
// Back end: executes queued items, chains keystream blocks, drives responses.
// Depends on rph_pkg, rph_ifs and the status of rph_md5.
`default_nettype none
module rph_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rph_pkg::item_type          item,
   input  wire logic                       item_valid,
   output logic                            item_ready,
   input  wire rph_pkg::md5_status_type    md5_status,
   input  wire logic [127:0]               md5_digest,
   output logic                            md5_start,
   output logic [127:0]                    chain,
   output logic                            ram_we,
   output logic [rph_pkg::SADDR_W-1:0]     ram_waddr,
   output logic [7:0]                      ram_wdata,
   rph_rsp_if.source                       rsp_ch
);
   rph_pkg::back_state_type state_ff, state_in;
   logic [127:0]              chain_ff, chain_in, ks_ff, ks_in, chain0;
   logic [7:0]                auth_ff [rph_pkg::AUTH_BYTES];
   logic [7:0]                auth_in [rph_pkg::AUTH_BYTES];
   logic [rph_pkg::POS_W-1:0] pos_ff, pos_in, pos0;
   logic                      inpw_ff, inpw_in, is_end_ff, is_end_in;
   logic [7:0]                plain_ff, plain_in, cbyte;
   logic                      rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [7:0]                rsp_byte_ff, rsp_byte_in;
   logic                      out_free, drop, run_done, is_pw;

   always_comb begin
      for (int k = 0; k < rph_pkg::AUTH_BYTES; k++) begin
         chain0[8*k +: 8] = auth_ff[k];
      end
      if (inpw_ff) begin
         chain0 = chain_ff;
      end
      pos0     = inpw_ff ? pos_ff : '0;
      drop     = pos0 >= rph_pkg::POS_W'(rph_pkg::MAX_PASSWORD_BYTES);
      is_pw    = item.op == rph_pkg::KIND_BYTE || item.op == rph_pkg::KIND_END;
      out_free = !rsp_valid_ff || rsp_ch.ready;
      run_done = !is_end_ff || pos_ff[3:0] == 4'hf;
      cbyte    = ks_ff[{pos_ff[3:0], 3'b000} +: 8] ^ plain_ff;
   end

   // next state
   always_comb begin
      case (state_ff)
         rph_pkg::BK_IDLE: begin
            state_in = rph_pkg::BK_IDLE;
            if (item_valid && is_pw && !(item.op == rph_pkg::KIND_BYTE && drop)) begin
               state_in = (pos0[3:0] == 4'h0) ? rph_pkg::BK_START : rph_pkg::BK_EMIT;
            end
         end
         rph_pkg::BK_START: state_in = rph_pkg::BK_HASH;
         rph_pkg::BK_HASH:  state_in = md5_status.done ? rph_pkg::BK_EMIT : rph_pkg::BK_HASH;
         rph_pkg::BK_EMIT:  state_in = (out_free && run_done) ? rph_pkg::BK_IDLE
                                                              : rph_pkg::BK_EMIT;
         default:           state_in = rph_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      item_ready          = state_ff == rph_pkg::BK_IDLE;
      md5_start           = state_ff == rph_pkg::BK_START;
      chain               = chain_ff;
      ram_we              = item_ready && item_valid && item.op == rph_pkg::KIND_SECRET;
      ram_waddr           = item.index[rph_pkg::SADDR_W-1:0];
      ram_wdata           = item.value;
      rsp_ch.valid        = rsp_valid_ff;
      rsp_ch.encoded_byte = rsp_byte_ff;
      rsp_ch.last         = rsp_last_ff;
   end

   // datapath
   always_comb begin
      chain_in     = chain_ff;  ks_in = ks_ff;  auth_in = auth_ff;
      pos_in       = pos_ff;    inpw_in = inpw_ff;
      is_end_in    = is_end_ff; plain_in = plain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         rph_pkg::BK_IDLE: begin
            if (item_valid) begin
               if (item.op == rph_pkg::KIND_AUTH) begin
                  auth_in[item.index[3:0]] = item.value;
               end
               if (is_pw) begin
                  inpw_in   = 1'b1;
                  chain_in  = chain0;
                  pos_in    = pos0;
                  is_end_in = item.op == rph_pkg::KIND_END;
                  plain_in  = (item.op == rph_pkg::KIND_BYTE) ? item.value : 8'h00;
               end
            end
         end
         rph_pkg::BK_HASH: begin
            if (md5_status.done) begin
               ks_in = md5_digest;
            end
         end
         rph_pkg::BK_EMIT: begin
            if (out_free) begin
               chain_in[{pos_ff[3:0], 3'b000} +: 8] = cbyte;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = cbyte;
               rsp_last_in  = is_end_ff && pos_ff[3:0] == 4'hf;
               pos_in       = pos_ff + 1'b1;
               if (is_end_ff && pos_ff[3:0] == 4'hf) begin
                  pos_in  = '0;
                  inpw_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      chain_ff    <= chain_in;
      ks_ff       <= ks_in;
      auth_ff     <= auth_in;
      is_end_ff   <= is_end_in;
      plain_ff    <= plain_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= rph_pkg::BK_IDLE;
         pos_ff       <= '0;
         inpw_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         inpw_ff      <= inpw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      md5_start |-> !md5_status.busy)
      else $error("hash started while MD5 unit busy");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rph_pkg::BK_EMIT && out_free && rsp_last_in) |-> is_end_ff)
      else $error("last flagged outside a pad run");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= rph_pkg::POS_W'(rph_pkg::MAX_PASSWORD_BYTES + 15))
      else $error("byte position out of range");
   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      md5_status.done |-> state_ff == rph_pkg::BK_HASH)
      else $error("digest arrived outside hash wait");
`endif
endmodule
`default_nettype wire

/* rtl/radius_password_hiding.sv */
// Top level of the RADIUS User-Password hiding block: CSR, front, back, MD5, RAM.
// Depends on rph_pkg, rph_ifs, rph_ram, rph_front, rph_md5 and rph_back.
//
//   channel   direction  handshake            payload
//   req_ch    in         valid/ready          kind[1:0], index[5:0], value[7:0]
//   rsp_ch    out        valid/ready          encoded_byte[7:0], last
//   csr_*     in         APB, pready tied 1   secret_length at byte address 0
//
// Flow: a load passes through the queue to the back end; later bytes of a block
// use the stored keystream, but the first byte of each 16-byte block waits for
// the iterative MD5 unit, which fills, runs its rounds and adds once per 64-byte
// MD5 block, one MD5 block for secret_length below 40, two from 40 up.
// Reset: synchronous, clears queue, control state and secret_length to 1.
// Stalls: the 4-entry queue accepts while the back end hashes or a response waits, until it is full.
`default_nettype none
module radius_password_hiding (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rph_req_if.sink                                req_ch,
   rph_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rph_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [rph_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [rph_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   logic [rph_pkg::SL_W-1:0]    secret_length_ff, secret_length_in, sl_sat;
   rph_pkg::item_type           q_item;
   logic                        q_valid, q_ready;
   rph_pkg::md5_status_type     md5_status;
   logic [127:0]                md5_digest, chain;
   logic                        md5_start, ram_we;
   logic [rph_pkg::SADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]                  ram_wdata, ram_rdata;
   logic                        csr_wr;

   // CSR: write on the access phase, read returns the stored length
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       csr_paddr[2] == rph_pkg::REG_SECRET_LENGTH;

   always_comb begin
      secret_length_in = secret_length_ff;
      if (csr_wr) begin
         secret_length_in = csr_pwdata[rph_pkg::SL_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == rph_pkg::REG_SECRET_LENGTH) begin
         csr_prdata = rph_pkg::CSR_DATA_W'(secret_length_ff);
      end
      // saturate oversize lengths to the secret store depth
      sl_sat = (secret_length_ff > rph_pkg::SL_W'(rph_pkg::MAX_SECRET_BYTES))
             ? rph_pkg::SL_W'(rph_pkg::MAX_SECRET_BYTES) : secret_length_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         secret_length_ff <= rph_pkg::SECRET_LENGTH_RESET;
      end else begin
         secret_length_ff <= secret_length_in;
      end
   end

   // accept and classify requests, hold them in a short queue
   rph_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_ready (q_ready)
   );

   // secret bytes: written by the back end, read by the MD5 fill
   rph_ram #(
      .WIDTH (8),
      .DEPTH (rph_pkg::MAX_SECRET_BYTES)
   ) u_secret_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rph_md5 u_md5 (
      .clock     (clock),
      .reset     (reset),
      .start     (md5_start),
      .sl        (sl_sat),
      .chain     (chain),
      .ram_rdata (ram_rdata),
      .ram_raddr (ram_raddr),
      .status    (md5_status),
      .digest    (md5_digest)
   );

   // execute loads and hide bytes in request order
   rph_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (q_item),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .md5_status (md5_status),
      .md5_digest (md5_digest),
      .md5_start  (md5_start),
      .chain      (chain),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .rsp_ch     (rsp_ch)
   );
endmodule
`default_nettype wire
